// ===== src/fbpa_pkg.sv =====
// ----------------------------------------------------------------------------
// fbpa_pkg
// Shared widths, codes, queue item type and helpers of the block pool
// allocator.
// ----------------------------------------------------------------------------
package fbpa_pkg;

    // pool geometry
    localparam int POOL_BLOCKS = 64;
    localparam int BLK_W       = (POOL_BLOCKS > 1) ? $clog2(POOL_BLOCKS) : 1;
    localparam int CNT_W       = $clog2(POOL_BLOCKS + 1);

    // field widths
    localparam int OFF_W = 18;
    localparam int BS_W  = 13;
    localparam int FC_W  = 7;
    localparam int ST_W  = 2;

    // block size limits
    localparam int BS_MAX = 4096;

    // front to back queue
    localparam int QDEPTH = 2;
    localparam int QAW    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCW    = $clog2(QDEPTH + 1);

    // request codes
    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    // status codes
    localparam logic [ST_W-1:0] ST_OK      = 2'd0;
    localparam logic [ST_W-1:0] ST_EMPTY   = 2'd1;
    localparam logic [ST_W-1:0] ST_BADFREE = 2'd2;

    // configuration register addresses (byte address bit 2 selects the word)
    localparam int          PADDR_W       = 3;
    localparam logic        REG_BLK_BYTES = 1'b0;

    // classified request, handed from front to back
    typedef struct packed {
        logic             req;
        logic             bad;
        logic [BLK_W-1:0] blk;
    } t_item;

    localparam int FCX_W = (CNT_W > FC_W) ? CNT_W : FC_W;

    // free blocks left for a given reserved count, wrapped to the port width
    function automatic logic [FC_W-1:0] free_cnt(input logic [CNT_W-1:0] rc);
        logic [FCX_W-1:0] diff;
        diff = FCX_W'(POOL_BLOCKS) - FCX_W'(rc);
        return diff[FC_W-1:0];
    endfunction

endpackage

// ===== src/fbpa_front.sv =====
// ----------------------------------------------------------------------------
// fbpa_front
// Accepts requests, turns a free offset into a block number with a
// one-bit-per-cycle restoring divider, flags out-of-range frees and pushes
// the classified request into the queue.
// ----------------------------------------------------------------------------
module fbpa_front
    import fbpa_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic             i_req_type,
    input  logic [OFF_W-1:0] i_free_offset,
    input  logic [BS_W-1:0]  i_bs,
    input  logic             i_q_full,
    output logic             o_q_push,
    output t_item            o_q_item
);

    localparam int DW = (BS_W + BLK_W > OFF_W) ? BS_W + BLK_W : OFF_W;
    localparam int SW = (BLK_W > 1) ? $clog2(BLK_W) : 1;

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_DIV  = 3'b010,
        F_PUSH = 3'b100
    } t_fstate;

    t_fstate          r_state, n_state;
    t_item            r_item;
    logic [DW-1:0]    r_rem, r_div;
    logic [BLK_W-1:0] r_q;
    logic [SW-1:0]    r_step;

    logic             accept;
    logic             ge;
    logic [DW-1:0]    n_rem;
    logic [BLK_W-1:0] n_q;
    logic             last_step;
    logic             bad_range;

    assign accept    = (r_state == F_IDLE) && i_in_valid;
    assign ge        = (r_rem >= r_div);
    assign n_rem     = ge ? (r_rem - r_div) : r_rem;
    assign n_q       = BLK_W'({r_q, ge});
    assign last_step = (r_step == '0);
    // quotient overflowed the counter, or points past the pool
    assign bad_range = (n_rem >= DW'(i_bs)) || (CNT_W'(n_q) >= CNT_W'(POOL_BLOCKS));

    assign o_in_stall = (r_state != F_IDLE);
    assign o_q_push   = (r_state == F_PUSH) && !i_q_full;
    assign o_q_item   = r_item;

    always_comb begin
        n_state = r_state;
        case (r_state)
            F_IDLE: begin
                if (accept) begin
                    n_state = (i_req_type == REQ_FREE) ? F_DIV : F_PUSH;
                end
            end
            F_DIV: begin
                if (last_step) begin
                    n_state = F_PUSH;
                end
            end
            F_PUSH: begin
                if (!i_q_full) begin
                    n_state = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item.req <= i_req_type;
            r_item.bad <= 1'b0;
            r_item.blk <= '0;
            r_rem      <= DW'(i_free_offset);
            r_div      <= DW'(i_bs) << (BLK_W - 1);
            r_q        <= '0;
            r_step     <= SW'(BLK_W - 1);
        end else if (r_state == F_DIV) begin
            r_rem  <= n_rem;
            r_div  <= r_div >> 1;
            r_q    <= n_q;
            r_step <= r_step - 1'b1;
            if (last_step) begin
                r_item.blk <= n_q;
                r_item.bad <= bad_range;
            end
        end
    end

endmodule

// ===== src/fbpa_queue.sv =====
// ----------------------------------------------------------------------------
// fbpa_queue
// Short FIFO of classified requests between front and back.
// ----------------------------------------------------------------------------
module fbpa_queue
    import fbpa_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_empty,
    output t_item o_head
);

    t_item            r_mem [QDEPTH];
    logic [QAW-1:0]   r_wp, r_rp;
    logic [QCW-1:0]   r_cnt;

    assign o_full  = (r_cnt == QCW'(QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rp];

    function automatic logic [QAW-1:0] nxt(input logic [QAW-1:0] p);
        return (p == QAW'(QDEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= nxt(r_wp);
            end
            if (i_pop) begin
                r_rp <= nxt(r_rp);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

endmodule

// ===== src/fbpa_back.sv =====
// ----------------------------------------------------------------------------
// fbpa_back
// Owns the free stack and the reserved count: pops or pushes block numbers,
// scales allocated block numbers to byte offsets and holds the result.
// ----------------------------------------------------------------------------
module fbpa_back
    import fbpa_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_empty,
    input  t_item            i_q_head,
    output logic             o_q_pop,
    input  logic [BS_W-1:0]  i_bs,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic [ST_W-1:0]  o_status,
    output logic [OFF_W-1:0] o_block_offset,
    output logic [FC_W-1:0]  o_free_count
);

    localparam int PW = (BLK_W + BS_W > OFF_W) ? BLK_W + BS_W : OFF_W;

    typedef enum logic [1:0] {
        B_IDLE = 2'b01,
        B_RD   = 2'b10
    } t_bstate;

    t_bstate            r_state, n_state;
    logic [CNT_W-1:0]   r_rc, n_rc;
    logic [BLK_W-1:0]   r_stack [POOL_BLOCKS];
    logic [POOL_BLOCKS-1:0] r_vld;
    logic [BLK_W-1:0]   r_rd_data, r_rd_idx;
    logic               r_rd_vld;

    logic               r_out_valid;
    logic [ST_W-1:0]    r_status;
    logic [OFF_W-1:0]   r_offset;
    logic [FC_W-1:0]    r_fc;

    logic               out_free, start;
    logic               load, mem_we, mem_re;
    logic [ST_W-1:0]    ld_status;
    logic [OFF_W-1:0]   ld_off;
    logic [CNT_W-1:0]   rc_dec;
    logic [BLK_W-1:0]   rd_idx, wr_idx, blk;
    logic [PW-1:0]      prod;

    assign out_free = !r_out_valid || !i_out_stall;
    assign start    = (r_state == B_IDLE) && !i_q_empty && out_free;
    assign o_q_pop  = start;

    assign rc_dec = r_rc - 1'b1;
    assign rd_idx = r_rc[BLK_W-1:0];
    assign wr_idx = rc_dec[BLK_W-1:0];
    // an entry never written reads as its own index, through its valid bit
    assign blk    = r_rd_vld ? r_rd_data : r_rd_idx;
    assign prod   = PW'(blk) * PW'(i_bs);

    always_comb begin
        n_state   = r_state;
        n_rc      = r_rc;
        load      = 1'b0;
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        ld_status = ST_OK;
        ld_off    = '0;
        case (r_state)
            B_IDLE: begin
                if (start) begin
                    if (i_q_head.req == REQ_ALLOC) begin
                        if (r_rc == CNT_W'(POOL_BLOCKS)) begin
                            load      = 1'b1;
                            ld_status = ST_EMPTY;
                        end else begin
                            mem_re  = 1'b1;
                            n_rc    = r_rc + 1'b1;
                            n_state = B_RD;
                        end
                    end else begin
                        if ((r_rc == '0) || i_q_head.bad) begin
                            load      = 1'b1;
                            ld_status = ST_BADFREE;
                        end else begin
                            n_rc   = rc_dec;
                            mem_we = 1'b1;
                            load   = 1'b1;
                        end
                    end
                end
            end
            B_RD: begin
                load    = 1'b1;
                ld_off  = prod[OFF_W-1:0];
                n_state = B_IDLE;
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_rc        <= '0;
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_rc    <= n_rc;
            if (mem_we) begin
                r_vld[wr_idx] <= 1'b1;
            end
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // free stack memory, registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_stack[wr_idx] <= i_q_head.blk;
        end
        if (mem_re) begin
            r_rd_data <= r_stack[rd_idx];
            r_rd_vld  <= r_vld[rd_idx];
            r_rd_idx  <= rd_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_status <= ld_status;
            r_offset <= ld_off;
            r_fc     <= free_cnt(n_rc);
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_status;
    assign o_block_offset = r_offset;
    assign o_free_count   = r_fc;

endmodule

// ===== src/fixed_block_pool_allocator.sv =====
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator
// Fixed-size block pool managed by a stack of free block numbers: allocate
// pops a block and returns its byte offset, free divides an offset by the
// block size and pushes the block number back.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                  payload
//  --------  ---------  -------------------------  -----------------------------
//  request   in         i_in_valid / o_in_stall     i_req_type, i_free_offset
//  result    out        o_out_valid / i_out_stall   o_status, o_block_offset,
//                                                   o_free_count
//  config    in         APB psel/penable/pready     block bytes at byte address 0
//
//  Steps: the front pushes an allocate straight to the queue and first runs
//  a free through the one-bit-per-cycle divider. The back handles a
//  successful allocate as a stack read and then a scale, and any other
//  request directly from its idle state.
//  Reset: synchronous, active low; the free stack reads as 0..N-1 through
//  per-entry valid bits, so no clearing pass is needed.
//  Stalls: a 2-entry queue parts front and back; a held result does not
//  stop the front from taking the next transfer while the queue has room.
//
module fixed_block_pool_allocator
    import fbpa_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,

    // request channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_req_type,
    input  logic [OFF_W-1:0]   i_free_offset,

    // result channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [ST_W-1:0]    o_status,
    output logic [OFF_W-1:0]   o_block_offset,
    output logic [FC_W-1:0]    o_free_count,

    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic [BS_W-1:0] r_blk_bytes;
    logic [BS_W-1:0] bs_eff;
    logic            cfg_wr;

    logic            q_push, q_full, q_pop, q_empty;
    t_item           q_in, q_head;

    // ---- configuration ----
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blk_bytes <= BS_W'(64);
        end else if (cfg_wr && (paddr[2] == REG_BLK_BYTES)) begin
            r_blk_bytes <= pwdata[BS_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_BLK_BYTES) ? 32'(r_blk_bytes) : '0;

    // clamp block size: zero acts as one, anything past the maximum as the maximum
    always_comb begin
        if (r_blk_bytes == '0) begin
            bs_eff = BS_W'(1);
        end else if (r_blk_bytes > BS_W'(BS_MAX)) begin
            bs_eff = BS_W'(BS_MAX);
        end else begin
            bs_eff = r_blk_bytes;
        end
    end

    // ---- front: accept, divide, classify ----
    fbpa_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_req_type    (i_req_type),
        .i_free_offset (i_free_offset),
        .i_bs          (bs_eff),
        .i_q_full      (q_full),
        .o_q_push      (q_push),
        .o_q_item      (q_in)
    );

    // ---- queue between the two halves ----
    fbpa_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_head  (q_head)
    );

    // ---- back: stack update and result ----
    fbpa_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_empty      (q_empty),
        .i_q_head       (q_head),
        .o_q_pop        (q_pop),
        .i_bs           (bs_eff),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_status       (o_status),
        .o_block_offset (o_block_offset),
        .o_free_count   (o_free_count)
    );

    // ---- checks ----
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full)
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_empty)
        else $error("queue pop while empty");

    a_offset_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status != ST_OK)) |-> (o_block_offset == '0))
        else $error("nonzero offset on failed request");

    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == ST_EMPTY)) |-> (o_free_count == '0))
        else $error("pool empty reported with free blocks left");

endmodule

// ===== verif/tb_fixed_block_pool_allocator.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_fixed_block_pool_allocator
// Self-checking bench for the block pool allocator. Requests go in through
// the valid/stall request channel. The bench keeps its own copy of the free
// stack, the reserved count and the block size, and works out each result
// when its request transfers. A checker compares every result transfer with
// the oldest prediction. The block size register is written over the config
// port only while the pool is idle, with the extreme sizes among those used.
// ----------------------------------------------------------------------------
module tb_fixed_block_pool_allocator;
    import fbpa_pkg::*;

    localparam int CLK_HALF         = 6;        // 12 ns period
    localparam int RESET_CYCLES     = 12;
    localparam int IDLE_PCT         = 24;       // idle cycles per hundred, each side
    localparam int SETTLE_CYCLES    = 12;       // longest latency (free) plus margin
    localparam int ITEMS_PER_PHASE  = 130;
    localparam int WELL_FORMED_PCT  = 90;
    localparam int FOLLOW_TREND_PCT = 85;
    localparam int CYCLE_LIMIT      = 500_000;

    localparam logic [PADDR_W-1:0] BLK_BYTES_ADDR = {REG_BLK_BYTES, 2'b00};

    // one result as the block should report it
    typedef struct {
        logic [ST_W-1:0]  status;
        logic [OFF_W-1:0] offset;
        logic [FC_W-1:0]  count;
    } t_pool_result;

    // ------------------------------------------------------------------------
    // DUT ports, inputs all known from time zero
    // ------------------------------------------------------------------------
    logic               i_clk          = 1'b0;
    logic               i_rst_n        = 1'b0;
    logic               i_in_valid     = 1'b0;
    logic               o_in_stall;
    logic               i_req_type     = REQ_ALLOC;
    logic [OFF_W-1:0]   i_free_offset  = '0;
    logic               o_out_valid;
    logic               i_out_stall    = 1'b0;
    logic [ST_W-1:0]    o_status;
    logic [OFF_W-1:0]   o_block_offset;
    logic [FC_W-1:0]    o_free_count;
    logic               psel           = 1'b0;
    logic               penable        = 1'b0;
    logic               pwrite         = 1'b0;
    logic [PADDR_W-1:0] paddr          = '0;
    logic [31:0]        pwdata         = '0;
    logic [31:0]        prdata;
    logic               pready;

    // ------------------------------------------------------------------------
    // Bench copy of the pool state
    // ------------------------------------------------------------------------
    logic [BLK_W-1:0] model_stack [POOL_BLOCKS];
    int unsigned      model_reserved;
    logic [BS_W-1:0]  model_blk_bytes;

    t_pool_result     predicted_results [$];  // oldest first
    int unsigned      held_blocks [$];        // block numbers handed out, not yet freed
    int unsigned      error_count = 0;
    int unsigned      cycle_count = 0;
    bit               steady_run  = 1'b0;     // suppress idling on both sides

    fixed_block_pool_allocator u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_req_type     (i_req_type),
        .i_free_offset  (i_free_offset),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_status       (o_status),
        .o_block_offset (o_block_offset),
        .o_free_count   (o_free_count),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // Abort a hung run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Result side stalls at random, never during a steady stretch.
    always @(posedge i_clk) begin
        i_out_stall <= !steady_run && ($urandom_range(99) < IDLE_PCT);
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    // Clamp the register to the size the block actually scales with.
    function automatic int unsigned effective_block_size();
        if (model_blk_bytes == '0) return 1;
        if (model_blk_bytes > BS_MAX) return BS_MAX;
        return 32'(model_blk_bytes);
    endfunction

    // Apply one request to the bench state and return what the block reports.
    function automatic t_pool_result predict_pool_request(input logic req,
                                                          input logic [OFF_W-1:0] off);
        t_pool_result res;
        int unsigned  bsize;
        int unsigned  blk;
        bsize      = effective_block_size();
        res.status = ST_OK;
        res.offset = '0;
        if (req == REQ_ALLOC) begin
            if (model_reserved >= POOL_BLOCKS) begin
                res.status = ST_EMPTY;
            end else begin
                blk = 32'(model_stack[model_reserved]);
                model_reserved++;
                res.offset = OFF_W'(blk * bsize);
            end
        end else begin
            blk = off / bsize;
            if (model_reserved == 0 || blk >= POOL_BLOCKS) begin
                res.status = ST_BADFREE;
            end else begin
                model_reserved--;
                model_stack[model_reserved] = BLK_W'(blk);
            end
        end
        res.count = FC_W'(POOL_BLOCKS - model_reserved);
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------
    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endtask

    // Compare each result transfer with the oldest prediction.
    always @(posedge i_clk) begin
        t_pool_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (predicted_results.size() == 0) begin
                $error("result transfer with no request outstanding");
                error_count++;
            end else begin
                want = predicted_results.pop_front();
                check_field("status", 32'(want.status), 32'(o_status));
                check_field("block_offset", 32'(want.offset), 32'(o_block_offset));
                check_field("free_count", 32'(want.count), 32'(o_free_count));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Shared drivers
    // ------------------------------------------------------------------------

    // Send one request: idle at random first, then hold the payload until it
    // transfers, and record the prediction at the transfer edge.
    task automatic send_request(input logic req, input logic [OFF_W-1:0] off,
                                output t_pool_result res);
        while (!steady_run && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_req_type    <= req;
        i_free_offset <= off;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        res = predict_pool_request(req, off);
        predicted_results.push_back(res);
    endtask

    // Drop valid, wait for every outstanding result, then let the block settle.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (predicted_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // One config access: setup cycle, access cycle, then an idle cycle.
    task automatic cfg_access(input logic is_write, input logic [31:0] wdata,
                              output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= BLK_BYTES_ADDR;
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic write_blk_bytes(input logic [BS_W-1:0] value);
        logic [31:0] unused;
        cfg_access(1'b1, 32'(value), unused);
        model_blk_bytes = value;
    endtask

    task automatic check_blk_bytes_reg();
        logic [31:0] rdata;
        cfg_access(1'b0, '0, rdata);
        check_field("blk_bytes", 32'(model_blk_bytes), rdata);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Reset value reads back, and written values read back, among them the clamp limit and the largest register value.
    task automatic test_config_port();
        check_blk_bytes_reg();
        write_blk_bytes(13'd4096);
        check_blk_bytes_reg();
        write_blk_bytes(13'h1FFF);
        check_blk_bytes_reg();
        write_blk_bytes(13'd64);
        check_blk_bytes_reg();
    endtask

    // Hand-picked requests around the edges of the offset range and the
    // block size clamps.
    task automatic test_boundary_requests();
        t_pool_result res;
        // block size 64: bad frees on an empty reservation and past the pool
        send_request(REQ_FREE,  18'h00000, res);   // nothing reserved
        send_request(REQ_FREE,  18'h3FFFF, res);
        send_request(REQ_ALLOC, 18'h3FFFF, res);   // offset field ignored
        send_request(REQ_FREE,  18'd4096,  res);   // block 64, out of range
        send_request(REQ_FREE,  18'd63,    res);   // truncates to block 0
        send_request(REQ_ALLOC, 18'h00000, res);
        send_request(REQ_ALLOC, 18'h00000, res);
        send_request(REQ_FREE,  18'd4095,  res);   // block 63 never handed out
        send_request(REQ_ALLOC, 18'h00000, res);   // hands block 63 back
        wait_idle();

        // size zero behaves as one byte per block
        write_blk_bytes(13'd0);
        send_request(REQ_FREE,  18'd64,    res);
        send_request(REQ_FREE,  18'd63,    res);
        send_request(REQ_ALLOC, 18'h15555, res);
        send_request(REQ_FREE,  18'd0,     res);
        wait_idle();

        // sizes above the maximum clamp to 4096
        write_blk_bytes(13'h1FFF);
        send_request(REQ_ALLOC, 18'h2AAAA, res);
        send_request(REQ_FREE,  18'h3FFFF, res);   // block 63
        send_request(REQ_ALLOC, 18'h00000, res);   // top of the offset range
        send_request(REQ_FREE,  18'd4096,  res);
        wait_idle();
    endtask

    // Random traffic over several block sizes. Requests follow a fill or
    // drain trend so the pool runs full and empty repeatedly; most frees
    // return a block that was handed out, the rest are random offsets.
    task automatic test_random_traffic();
        logic [BS_W-1:0] sizes [7];
        t_pool_result    res;
        bit              filling;
        bit              do_alloc;
        int unsigned     bsize;
        int unsigned     idx;
        int unsigned     blk;
        logic [OFF_W-1:0] off;
        sizes = '{13'd1, 13'd4096, 13'd64, 13'h1FFF, 13'd0,
                  13'($urandom_range(4096, 1)), 13'($urandom)};
        filling = 1'b1;
        foreach (sizes[p]) begin
            wait_idle();
            write_blk_bytes(sizes[p]);
            check_blk_bytes_reg();
            steady_run = (p == 2);   // one whole phase without idling
            bsize = effective_block_size();
            repeat (ITEMS_PER_PHASE) begin
                // turn around after dwelling a little at either end
                if (filling && model_reserved == POOL_BLOCKS && $urandom_range(3) == 0)
                    filling = 1'b0;
                else if (!filling && model_reserved == 0 && $urandom_range(3) == 0)
                    filling = 1'b1;
                do_alloc = ($urandom_range(99) < FOLLOW_TREND_PCT) ? filling : !filling;

                if (do_alloc) begin
                    send_request(REQ_ALLOC, OFF_W'($urandom), res);
                    if (res.status == ST_OK)
                        held_blocks.push_back(32'(model_stack[model_reserved - 1]));
                end else begin
                    if (held_blocks.size() != 0 && $urandom_range(99) < WELL_FORMED_PCT) begin
                        idx = $urandom_range(held_blocks.size() - 1);
                        blk = held_blocks[idx];
                        held_blocks.delete(idx);
                        off = OFF_W'(blk * bsize + $urandom_range(bsize - 1));
                    end else if ($urandom_range(1) == 0) begin
                        off = OFF_W'($urandom);
                    end else begin
                        // just past the last block
                        off = OFF_W'(POOL_BLOCKS * bsize + $urandom_range(bsize - 1));
                    end
                    send_request(REQ_FREE, off, res);
                end
            end
            steady_run = 1'b0;
        end
        wait_idle();
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        for (int i = 0; i < POOL_BLOCKS; i++) model_stack[i] = BLK_W'(i);
        model_reserved  = 0;
        model_blk_bytes = 13'd64;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_config_port();
        test_boundary_requests();
        test_random_traffic();

        if (error_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
